FILE: src/deq_pkg.sv
// Package for the double-ended queue: command and status codes, the
// per-cell control group and default sizes. No dependencies.
package deq_pkg;

	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One operation broadcast to every cell of the row in a cycle.
	typedef struct packed {
		logic shift_right;  // push at the front: every entry moves one cell back
		logic shift_left;   // pop at the front: every entry moves one cell forward
		logic load_back;    // push at the back: first free cell takes the word
		logic drop_back;    // pop at the back: last occupied cell empties
	} cell_ctrl_t;

endpackage

FILE: src/deq_cell.sv
// One storage cell of the queue row: a data word and an occupied flag.
// Depends on deq_pkg for the control group.
module deq_cell #(
	parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  deq_pkg::cell_ctrl_t    ctrl,
	input  logic [DATA_WIDTH-1:0]  push_data,
	input  logic [DATA_WIDTH-1:0]  left_data,
	input  logic                   left_occ,
	input  logic [DATA_WIDTH-1:0]  right_data,
	input  logic                   right_occ,
	output logic [DATA_WIDTH-1:0]  data,
	output logic                   occ
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  occ_q;
	logic [DATA_WIDTH-1:0] data_nxt;
	logic                  occ_nxt;

	// The front neighbor is the only one that can tell this cell it is the
	// first free one, and the back neighbor that this cell is the last used.
	always_comb begin
		data_nxt = data_q;
		occ_nxt  = occ_q;
		priority if (ctrl.shift_right) begin
			data_nxt = left_data;
			occ_nxt  = left_occ;
		end else if (ctrl.shift_left) begin
			data_nxt = right_data;
			occ_nxt  = right_occ;
		end else if (ctrl.load_back && !occ_q && left_occ) begin
			data_nxt = push_data;
			occ_nxt  = 1'b1;
		end else if (ctrl.drop_back && occ_q && !right_occ) begin
			occ_nxt  = 1'b0;
		end else begin
			data_nxt = data_q;
			occ_nxt  = occ_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_nxt;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;
	assign occ  = occ_q;

endmodule

FILE: src/double_ended_queue.sv
// Top level of the double-ended queue: a row of deq_cell storage cells,
// command decode, fill counter and the registered result beat. Uses deq_pkg.
//
//   Channel  Direction  Handshake             Payload
//   in       to block   in_valid / in_stall   cmd, data_in
//   out      from block out_valid / out_stall data_out, status, fill_after
//
// Each command beat is executed in the cycle it is accepted, and its result
// beat appears in the output register on the next cycle, so one command is
// taken per cycle as long as results are taken. The rate is set by the cell
// row, which moves every entry by one cell at once.
// Reset clears every occupied flag and the fill counter; stored words are not
// cleared and are never read before a push writes them.
// The input stalls only while a result beat is held in the output register
// and the output is stalled.
module double_ended_queue #(
	parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
	localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [2:0]             cmd,
	input  logic [DATA_WIDTH-1:0]  data_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [DATA_WIDTH-1:0]  data_out,
	output logic [1:0]             status,
	output logic [CNT_W-1:0]       fill_after
);

	// Cell row. Cell 0 always holds the front entry; occupied cells form an
	// unbroken run from cell 0, so the back entry is the last occupied cell.
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]      cell_occ;
	logic [DEPTH-1:0]      is_back;
	deq_pkg::cell_ctrl_t   ctrl;

	logic                  accept;
	deq_pkg::cmd_t         cmd_e;
	logic                  is_empty;
	logic                  is_full;
	logic [DATA_WIDTH-1:0] back_data;

	logic [DATA_WIDTH-1:0] rd_data;
	deq_pkg::status_t      rd_status;
	logic                  cnt_inc;
	logic                  cnt_dec;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic [1:0]            out_status_q;
	logic [CNT_W-1:0]      out_fill_q;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [DATA_WIDTH-1:0] l_data;
			logic                  l_occ;
			logic [DATA_WIDTH-1:0] r_data;
			logic                  r_occ;

			// The first cell sees the pushed word as its front neighbor, with
			// an always-occupied flag; the last cell sees an empty back neighbor.
			if (gi == 0) begin : g_head
				assign l_data = data_in;
				assign l_occ  = 1'b1;
			end else begin : g_mid
				assign l_data = cell_data[gi-1];
				assign l_occ  = cell_occ[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign r_data = '0;
				assign r_occ  = 1'b0;
			end else begin : g_next
				assign r_data = cell_data[gi+1];
				assign r_occ  = cell_occ[gi+1];
			end

			deq_cell #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.push_data  (data_in),
				.left_data  (l_data),
				.left_occ   (l_occ),
				.right_data (r_data),
				.right_occ  (r_occ),
				.data       (cell_data[gi]),
				.occ        (cell_occ[gi])
			);

			assign is_back[gi] = cell_occ[gi] && !r_occ;
		end
	endgenerate

	// At most one cell is the back entry, so an AND-OR picks its word.
	always_comb begin
		back_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_data = back_data | (cell_data[i] & {DATA_WIDTH{is_back[i]}});
		end
	end

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign cmd_e    = deq_pkg::cmd_t'(cmd);
	assign is_empty = !cell_occ[0];
	assign is_full  = cell_occ[DEPTH-1];

	// Command decode. Refused pushes and pops on an empty queue leave the
	// row and the counter alone; unknown codes do nothing and report ok.
	always_comb begin
		ctrl      = '0;
		rd_data   = '0;
		rd_status = deq_pkg::ST_OK;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		unique case (cmd_e)
			deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
				if (is_full) begin
					rd_status = deq_pkg::ST_FULL;
				end else begin
					ctrl.shift_right = accept && (cmd_e == deq_pkg::CMD_PUSH_FRONT);
					ctrl.load_back   = accept && (cmd_e == deq_pkg::CMD_PUSH_BACK);
					cnt_inc          = accept;
				end
			end
			deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT: begin
				if (is_empty) begin
					rd_status = deq_pkg::ST_EMPTY;
				end else begin
					rd_data         = cell_data[0];
					ctrl.shift_left = accept && (cmd_e == deq_pkg::CMD_POP_FRONT);
					cnt_dec         = accept && (cmd_e == deq_pkg::CMD_POP_FRONT);
				end
			end
			deq_pkg::CMD_POP_BACK, deq_pkg::CMD_PEEK_BACK: begin
				if (is_empty) begin
					rd_status = deq_pkg::ST_EMPTY;
				end else begin
					rd_data        = back_data;
					ctrl.drop_back = accept && (cmd_e == deq_pkg::CMD_POP_BACK);
					cnt_dec        = accept && (cmd_e == deq_pkg::CMD_POP_BACK);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		priority if (cnt_inc) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (cnt_dec) begin
			count_nxt = count_q - CNT_W'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result beat is loaded whenever a command is accepted; an accepted
	// command implies the previous beat has left or is leaving this cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q   <= rd_data;
			out_status_q <= rd_status;
			out_fill_q   <= count_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_out   = out_data_q;
	assign status     = out_status_q;
	assign fill_after = out_fill_q;

endmodule

FILE: src/deq_checker.sv
// Port-level checker for the double-ended queue and its bind to the top level.
// Depends on deq_pkg for status codes and default sizes.
module deq_checker #(
	parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
	localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic [2:0]             cmd,
	input logic [DATA_WIDTH-1:0]  data_in,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [DATA_WIDTH-1:0]  data_out,
	input logic [1:0]             status,
	input logic [CNT_W-1:0]       fill_after
);

	// A stalled result beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out) &&
			$stable(status) && $stable(fill_after))
		else $error("result beat changed while stalled");

	// The input only stalls behind a stalled result beat.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// Every accepted command shows a result beat on the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted command produced no result beat");

	// A full error only happens at capacity, an empty error only at zero.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == deq_pkg::ST_FULL |->
			fill_after == CNT_W'(DEPTH) && data_out == '0)
		else $error("full status with wrong count or data");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == deq_pkg::ST_EMPTY |->
			fill_after == '0 && data_out == '0)
		else $error("empty status with wrong count or data");

endmodule

bind double_ended_queue deq_checker #(
	.DEPTH      (DEPTH),
	.DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue: drives command beats, predicts each
// result beat with its own deque model and checks it field by field. Depends on deq_pkg.
module tb;

	localparam int unsigned DEPTH      = deq_pkg::DEPTH_DEF;
	localparam int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF;
	localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

	// Command codes 6 and 7 are not decoded; the block must answer them as no-ops.
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	localparam int RANDOM_BEATS  = 1080;
	localparam int IDLE_LIMIT    = 500;
	localparam int REPORT_LIMIT  = 10;

	typedef struct {
		logic [DATA_WIDTH-1:0] word;
		logic [1:0]            status;
		logic [CNT_W-1:0]      fill;
	} deque_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [2:0]            cmd = 3'd0;
	logic [DATA_WIDTH-1:0] data_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [DATA_WIDTH-1:0] data_out;
	logic [1:0]            status;
	logic [CNT_W-1:0]      fill_after;

	double_ended_queue #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.data_in(data_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out(data_out),
		.status(status),
		.fill_after(fill_after)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Mirror of the deque contents. The stored entries are deque_words[head_idx],
	// deque_words[head_idx + 1], ... wrapping at DEPTH, entry_count of them.
	logic [DATA_WIDTH-1:0] deque_words [DEPTH];
	int                    head_idx = 0;
	int                    entry_count = 0;

	deque_result_t pending_results[$];

	int error_count = 0;
	int beats_in = 0;
	int beats_out = 0;
	int full_refusals = 0;
	int empty_reads = 0;
	int spare_cmds = 0;
	int peak_fill = 0;
	int idle_cycles = 0;

	// Sender burst state: beats left in the current burst before a gap.
	int burst_left = 0;

	// Receiver stall pattern state.
	int  stall_mode = 0;
	int  mode_left = 0;
	int  stall_run = 0;
	bit  stall_next = 1'b0;

	// Applies one command to the mirror and returns the result beat it must produce.
	function automatic deque_result_t apply_deque_cmd(input logic [2:0] c,
			input logic [DATA_WIDTH-1:0] word);
		deque_result_t r;
		int            slot;
		r.word   = '0;
		r.status = deq_pkg::ST_OK;
		case (c)
			deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
				if (entry_count >= DEPTH) begin
					r.status = deq_pkg::ST_FULL;
					full_refusals++;
				end else if (c == deq_pkg::CMD_PUSH_FRONT) begin
					head_idx = (head_idx + DEPTH - 1) % DEPTH;
					deque_words[head_idx] = word;
					entry_count++;
				end else begin
					deque_words[(head_idx + entry_count) % DEPTH] = word;
					entry_count++;
				end
			end
			deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK,
			deq_pkg::CMD_PEEK_FRONT, deq_pkg::CMD_PEEK_BACK: begin
				if (entry_count == 0) begin
					r.status = deq_pkg::ST_EMPTY;
					empty_reads++;
				end else if (c == deq_pkg::CMD_POP_FRONT || c == deq_pkg::CMD_PEEK_FRONT) begin
					r.word = deque_words[head_idx];
					if (c == deq_pkg::CMD_POP_FRONT) begin
						head_idx = (head_idx + 1) % DEPTH;
						entry_count--;
					end
				end else begin
					slot = (head_idx + entry_count + DEPTH - 1) % DEPTH;
					r.word = deque_words[slot];
					if (c == deq_pkg::CMD_POP_BACK) begin
						entry_count--;
					end
				end
			end
			default: begin
				spare_cmds++;
			end
		endcase
		if (entry_count > peak_fill) begin
			peak_fill = entry_count;
		end
		r.fill = entry_count[CNT_W-1:0];
		return r;
	endfunction

	// Every accepted command beat is run through the mirror right away, so the
	// expectation is queued at the accepting edge, before its result beat can be taken.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			pending_results.push_back(apply_deque_cmd(cmd, data_in));
			beats_in++;
		end
	end

	task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] exp_val,
			input logic [DATA_WIDTH-1:0] got_val);
		error_count++;
		if (error_count <= REPORT_LIMIT) begin
			$display("%0t: mismatch on %s, expected %h, got %h", $realtime, what,
				exp_val, got_val);
		end
	endtask

	// Result checker: each taken result beat is held against the oldest expectation.
	always @(posedge clk) begin
		deque_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing outstanding", '0, data_out);
			end else begin
				exp_res = pending_results.pop_front();
				if (data_out !== exp_res.word) begin
					report_mismatch("data_out", exp_res.word, data_out);
				end
				if (status !== exp_res.status) begin
					report_mismatch("status", DATA_WIDTH'(exp_res.status),
						DATA_WIDTH'(status));
				end
				if (fill_after !== exp_res.fill) begin
					report_mismatch("fill_after", DATA_WIDTH'(exp_res.fill),
						DATA_WIDTH'(fill_after));
				end
			end
		end
	end

	// The receiver switches between modes of its own: no stalls at all, light
	// random stalls, heavy random stalls, and occasional long stall runs.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(40, 200);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: stall_next = 1'b0;
			1: stall_next = ($urandom_range(0, 3) == 0);
			2: stall_next = ($urandom_range(0, 9) < 6);
			default: begin
				if (stall_run == 0 && $urandom_range(0, 9) == 0) begin
					stall_run = $urandom_range(3, 10);
				end
				stall_next = (stall_run != 0);
				if (stall_run != 0) begin
					stall_run--;
				end
			end
		endcase
		out_stall <= stall_next;
	end

	// Watchdog: a run of cycles with no beat taken on either channel means a hang.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
				$realtime, IDLE_LIMIT, pending_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Presents one command beat and holds it until the block takes it. The sender
	// works in bursts; at the end of a burst valid drops for a random gap.
	task automatic send_beat(input logic [2:0] c, input logic [DATA_WIDTH-1:0] word);
		in_valid <= 1'b1;
		cmd      <= c;
		data_in  <= word;
		do @(posedge clk); while (in_stall);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end else begin
			burst_left--;
		end
	endtask

	// Drops valid so no stale beat is taken while the sender does something else.
	task automatic close_burst();
		in_valid <= 1'b0;
		@(posedge clk);
		burst_left = 0;
	endtask

	task automatic wait_all_results();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Data words lean toward the extremes (sign bit only, largest positive, zero, all ones) now and then.
	function automatic logic [DATA_WIDTH-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
			1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	// Every read command on an empty deque must report the empty error, and the
	// two spare codes must pass through as no-ops.
	task automatic test_empty_and_spare();
		send_beat(deq_pkg::CMD_POP_FRONT, '1);
		send_beat(deq_pkg::CMD_POP_BACK, '0);
		send_beat(deq_pkg::CMD_PEEK_FRONT, 32'h8000_0000);
		send_beat(deq_pkg::CMD_PEEK_BACK, 32'h7fff_ffff);
		send_beat(CMD_SPARE_LO, 32'hdead_beef);
		send_beat(CMD_SPARE_HI, 32'h1234_5678);
		close_burst();
	endtask

	// Fills the deque from both ends, starting with extreme words, then pushes into the full
	// deque at each end and reads both ends back.
	task automatic test_fill_and_overflow();
		send_beat(deq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
		send_beat(deq_pkg::CMD_PUSH_BACK, 32'h7fff_ffff);
		send_beat(deq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff);
		send_beat(deq_pkg::CMD_PUSH_BACK, 32'h0000_0000);
		for (int i = 4; i < DEPTH; i++) begin
			send_beat((i % 2 == 0) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK,
				pick_word());
		end
		send_beat(deq_pkg::CMD_PUSH_FRONT, 32'haaaa_aaaa);
		send_beat(deq_pkg::CMD_PUSH_BACK, 32'h5555_5555);
		send_beat(deq_pkg::CMD_PEEK_FRONT, '0);
		send_beat(deq_pkg::CMD_PEEK_BACK, '0);
		send_beat(deq_pkg::CMD_POP_FRONT, '0);
		send_beat(deq_pkg::CMD_POP_BACK, '0);
		close_burst();
	endtask

	// Random traffic in phases with a randomly chosen push share each time, so the fill
	// level sweeps between empty and full and the head index wraps many times.
	task automatic test_random_traffic();
		int sent;
		int phase_len;
		int push_pct;
		int roll;
		logic [2:0] c;
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			case ($urandom_range(0, 4))
				0: push_pct = 90;
				1: push_pct = 10;
				2: push_pct = 70;
				3: push_pct = 30;
				default: push_pct = 50;
			endcase
			phase_len = $urandom_range(40, 150);
			for (int i = 0; i < phase_len && sent < RANDOM_BEATS; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 2) begin
					c = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
				end else if (roll < 2 + push_pct) begin
					c = 3'($urandom_range(deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK));
				end else begin
					c = 3'($urandom_range(deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_BACK));
				end
				send_beat(c, pick_word());
				sent++;
			end
		end
		close_burst();
	endtask

	// The sender stops until every result has come back, then resumes: the block
	// has to pick up cleanly after its output side ran dry.
	task automatic test_pause_until_drained();
		for (int i = 0; i < 20; i++) begin
			send_beat(3'($urandom_range(deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK)),
				pick_word());
		end
		close_burst();
		wait_all_results();
		for (int i = 0; i < 20; i++) begin
			send_beat(3'($urandom_range(deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_BACK)),
				'0);
		end
		close_burst();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_spare();
		test_fill_and_overflow();
		test_pause_until_drained();
		test_random_traffic();

		// Let the last results out, then wait on to catch a stray beat.
		wait_all_results();
		repeat (10) @(posedge clk);

		$display("Ran %0d command beats and checked %0d result beats, peak fill %0d of %0d.",
			beats_in, beats_out, peak_fill, DEPTH);
		$display("Saw %0d full refusals, %0d empty reads, %0d spare codes; %0d mismatches.",
			full_refusals, empty_reads, spare_cmds, error_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
